### hw/rtl/hbb_pkg.sv
// hbb_pkg: shared widths, parameter defaults and state codes for the hash bucket build core
// no dependencies; imported by hash_bucket_build_core
`timescale 1ns / 1ps
`default_nettype none

package hbb_pkg;

   localparam int KEY_W        = 31;
   localparam int PAYLOAD_W    = 32;
   localparam int CSR_W        = 9;
   localparam int BUCKET_OUT_W = 8;
   localparam int BLOCK_OUT_W  = 9;
   localparam int SLOT_OUT_W   = 4;

   localparam logic [CSR_W-1:0] CSR_BUCKET_COUNT_RESET = 9'd256;

   localparam int DEF_NUM_BUCKETS     = 256;
   localparam int DEF_BLOCK_ROWS      = 16;
   localparam int DEF_OVERFLOW_BLOCKS = 256;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_CHECK,
      ST_ALLOC
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/hash_bucket_build_core.sv
// hash_bucket_build_core: hash join build side, rows appended to chained fixed-size blocks
// depends on hbb_pkg (widths, parameter defaults, state codes)
// a request divides its key bit-serially over all 31 key bits for the bucket, then reads
// the chain memory once per block walked, with an extra step when an overflow block is
// linked; busy drops in the cycle the result is shown, so a new request is taken only
// once the last one is done.
// reset: a clearing pass writes the NUM_BUCKETS primary chain entries while busy is high;
// results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module hash_bucket_build_core #(
   parameter int NUM_BUCKETS     = hbb_pkg::DEF_NUM_BUCKETS,
   parameter int BLOCK_ROWS      = hbb_pkg::DEF_BLOCK_ROWS,
   parameter int OVERFLOW_BLOCKS = hbb_pkg::DEF_OVERFLOW_BLOCKS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [hbb_pkg::KEY_W-1:0]        req_key,
   input  wire logic [hbb_pkg::PAYLOAD_W-1:0]    req_payload,
   output logic                                  rsp_valid,
   output logic [hbb_pkg::BUCKET_OUT_W-1:0]      rsp_bucket,
   output logic [hbb_pkg::BLOCK_OUT_W-1:0]       rsp_block,
   output logic [hbb_pkg::SLOT_OUT_W-1:0]        rsp_slot,
   output logic                                  rsp_stored,
   input  wire logic                             csr_wr_en,
   input  wire logic [hbb_pkg::CSR_W-1:0]        csr_wr_data
);
   import hbb_pkg::*;

   localparam int TOTAL  = NUM_BUCKETS + OVERFLOW_BLOCKS;
   localparam int ROWS   = TOTAL * BLOCK_ROWS;
   localparam int D_W    = $clog2(NUM_BUCKETS + 1);
   localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int BLK_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int FW     = $clog2(BLOCK_ROWS + 1);
   localparam int OVF_W  = (OVERFLOW_BLOCKS > 0) ? $clog2(OVERFLOW_BLOCKS + 1) : 1;
   localparam int RS_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W  = $clog2(KEY_W);
   localparam int CW     = (D_W > CSR_W) ? D_W : CSR_W;
   localparam int MW     = 1 + BLK_W + FW;
   localparam int ROW_W  = KEY_W + 1 + PAYLOAD_W;

   // chain memory word: {has_next, next_block, fill}
   logic [MW-1:0]    chain_mem [TOTAL];
   logic [ROW_W-1:0] row_mem [ROWS];

   state_type             state_ff, state_in;
   logic [BKT_W-1:0]      clr_ff, clr_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [KEY_W-1:0]      key_sh_ff, key_sh_in;
   logic [PAYLOAD_W-1:0]  pay_ff, pay_in;
   logic [D_W-1:0]        div_ff, div_in;
   logic [D_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [BLK_W-1:0]      blk_ff, blk_in;
   logic [BKT_W-1:0]      bucket_ff, bucket_in;
   logic [OVF_W-1:0]      ovf_ff, ovf_in;
   logic [CSR_W-1:0]      bucket_count_ff, bucket_count_in;
   logic [MW-1:0]         rd_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_OUT_W-1:0]      rsp_bucket_ff, rsp_bucket_in;
   logic [BLOCK_OUT_W-1:0]       rsp_block_ff, rsp_block_in;
   logic [SLOT_OUT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic                         rsp_stored_ff, rsp_stored_in;

   logic              mem_we;
   logic [BLK_W-1:0]  mem_waddr;
   logic [MW-1:0]     mem_wdata;
   logic              rs_we;
   logic [RS_W-1:0]   rs_waddr;

   logic [D_W-1:0]    div_eff;
   logic [D_W:0]      trial;
   logic [D_W-1:0]    rem_next;
   logic [FW-1:0]     rd_fill;
   logic [BLK_W-1:0]  rd_next;
   logic              rd_has;
   logic [BLK_W-1:0]  new_blk;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bucket = rsp_bucket_ff;
   assign rsp_block  = rsp_block_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_stored = rsp_stored_ff;

   assign rd_fill = rd_ff[FW-1:0];
   assign rd_next = rd_ff[FW+BLK_W-1:FW];
   assign rd_has  = rd_ff[MW-1];
   assign new_blk = BLK_W'(NUM_BUCKETS) + BLK_W'(ovf_ff);

   // zero count acts as one, large counts saturate
   always_comb begin
      if (bucket_count_ff == '0) begin
         div_eff = D_W'(1);
      end else if (CW'(bucket_count_ff) > CW'(NUM_BUCKETS)) begin
         div_eff = D_W'(NUM_BUCKETS);
      end else begin
         div_eff = D_W'(bucket_count_ff);
      end
   end

   // one restoring remainder step per cycle
   assign trial = {rem_ff, key_sh_ff[KEY_W-1]};
   always_comb begin
      if (trial >= {1'b0, div_ff}) begin
         rem_next = D_W'(trial - {1'b0, div_ff});
      end else begin
         rem_next = trial[D_W-1:0];
      end
   end

   assign bucket_count_in = csr_wr_en ? csr_wr_data : bucket_count_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      key_in        = key_ff;
      key_sh_in     = key_sh_ff;
      pay_in        = pay_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      blk_in        = blk_ff;
      bucket_in     = bucket_ff;
      ovf_in        = ovf_ff;
      mem_we        = 1'b0;
      mem_waddr     = blk_ff;
      mem_wdata     = '0;
      rs_we         = 1'b0;
      rs_waddr      = RS_W'(blk_ff) * RS_W'(BLOCK_ROWS) + RS_W'(rd_fill);
      rsp_valid_in  = 1'b0;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_stored_in = rsp_stored_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = BLK_W'(clr_ff);
            if (clr_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + BKT_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               key_in    = req_key;
               key_sh_in = req_key;
               pay_in    = req_payload;
               div_in    = div_eff;
               rem_in    = '0;
               cnt_in    = CNT_W'(KEY_W - 1);
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in    = rem_next;
            key_sh_in = {key_sh_ff[KEY_W-2:0], 1'b0};
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               blk_in    = BLK_W'(rem_next);
               bucket_in = BKT_W'(rem_next);
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // chain entry of blk_ff arrives next cycle
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_fill < FW'(BLOCK_ROWS)) begin
               mem_we        = 1'b1;
               mem_wdata     = {rd_has, rd_next, rd_fill + FW'(1)};
               rs_we         = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = BUCKET_OUT_W'(bucket_ff);
               rsp_block_in  = BLOCK_OUT_W'(blk_ff);
               rsp_slot_in   = SLOT_OUT_W'(rd_fill);
               rsp_stored_in = 1'b1;
               state_in      = ST_IDLE;
            end else if (rd_has) begin
               blk_in   = rd_next;
               state_in = ST_READ;
            end else if (ovf_ff < OVF_W'(OVERFLOW_BLOCKS)) begin
               // link a fresh overflow block behind the full tail
               mem_we    = 1'b1;
               mem_wdata = {1'b1, new_blk, rd_fill};
               blk_in    = new_blk;
               ovf_in    = ovf_ff + OVF_W'(1);
               state_in  = ST_ALLOC;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = BUCKET_OUT_W'(bucket_ff);
               rsp_block_in  = '0;
               rsp_slot_in   = '0;
               rsp_stored_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_ALLOC: begin
            // new block starts with this row in slot zero
            mem_we        = 1'b1;
            mem_wdata     = {1'b0, BLK_W'(0), FW'(1)};
            rs_we         = 1'b1;
            rs_waddr      = RS_W'(blk_ff) * RS_W'(BLOCK_ROWS);
            rsp_valid_in  = 1'b1;
            rsp_bucket_in = BUCKET_OUT_W'(bucket_ff);
            rsp_block_in  = BLOCK_OUT_W'(blk_ff);
            rsp_slot_in   = '0;
            rsp_stored_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         ovf_ff          <= '0;
         bucket_count_ff <= CSR_BUCKET_COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         ovf_ff          <= ovf_in;
         bucket_count_ff <= bucket_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      key_sh_ff     <= key_sh_in;
      pay_ff        <= pay_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      blk_ff        <= blk_in;
      bucket_ff     <= bucket_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_stored_ff <= rsp_stored_in;
   end

   // chain memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         chain_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= chain_mem[blk_ff];
   end

   // row storage, write only from this side of the join
   always_ff @(posedge clock) begin
      if (rs_we) begin
         row_mem[rs_waddr] <= {pay_ff, 1'b0, key_ff};
      end
   end

endmodule

`default_nettype wire
